[design/bps_pkg.sv]
// bps_pkg: shared types and constants of the byte pattern search block
// used by bps_cell and byte_pattern_search; depends on nothing
`default_nettype none
package bps_pkg;

	localparam int LEN_W    = 7;
	localparam int IDX_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int S_DATA_W = 16;
	localparam int OUT_W    = 32;
	localparam int ADDR_W   = 2;
	localparam int APB_W    = 32;

	localparam logic [ADDR_W-1:0] REG_PATTERN_LENGTH = 2'd0;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} op_t;

	typedef struct packed {
		logic             shift;
		logic             clear;
		logic             rotate;
		logic [LEN_W-1:0] len_eff;
	} bps_ctrl_t;

endpackage
`default_nettype wire

[design/byte_pattern_search.sv]
// byte_pattern_search: streaming exact byte pattern search over a row of cells
// depends on bps_pkg and bps_cell
//
// usage: load pattern bytes with s_tuser = 0 (index in s_tdata[5:0], byte in
// s_tdata[13:6]), set pattern_length over the APB port, then stream text
// bytes with s_tuser = 1 and s_tlast on the final byte of a region.
// the first full match in a region gives one word on the master side with
// m_tuser = 1 and the match start offset in m_tdata; a region that ends
// without a match gives m_tuser = 0 and m_tdata = 0.
// throughput is one word per cycle while s_tready is high: every cell
// compares its byte in the cycle the word is taken and the result lands in
// the output register, visible in the cycle after the text byte is accepted.
// the output register lets a new word in while no result is held or the
// held one is being taken; s_tready drops when m_tready is low with a
// result held, and also while the pattern ring rotates.
// after a pattern_length write the pattern ring in the cells rotates one
// position per cycle until it lines up with the new length, with s_tready
// low meanwhile.
// reset clears the text row, the byte count and the match flag, and sets
// pattern_length to 1; pattern bytes are undefined until loaded.
`default_nettype none
module byte_pattern_search #(
	parameter int MAX_PATTERN = 64,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// pattern_index [5:0], data_byte [13:6], zero [15:14]
	input  wire logic [bps_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input  wire logic                        s_tuser,
	input  wire logic                        s_tlast,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// match_offset [31:0]
	output logic      [bps_pkg::OUT_W-1:0]   m_tdata,
	// found
	output logic                             m_tuser,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bps_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bps_pkg::APB_W-1:0]   pwdata,
	output logic      [bps_pkg::APB_W-1:0]   prdata,
	output logic                             pready
);
	import bps_pkg::*;

	localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DW = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
	localparam logic [8:0] MaxC = 9'(MAX_PATTERN);

	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       len_eff;
	logic [PW-1:0]          top_q;
	logic                   aligned;
	logic                   cfg_we;
	logic                   out_free;
	logic                   acc;
	logic                   acc_text;
	logic                   acc_load;
	op_t                    op;
	logic [IDX_W-1:0]       ld_idx;
	logic [BYTE_W-1:0]      data;
	logic                   ld_ok;
	logic [8:0]             ld_diff;
	logic [PW-1:0]          ld_pos;
	bps_ctrl_t              ctrl;
	logic [BYTE_W-1:0]      win_q [MAX_PATTERN];
	logic [BYTE_W-1:0]      pat_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] valid_vec;
	logic [MAX_PATTERN-1:0] hit_vec;
	logic                   match;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [OFFSET_BITS-1:0] cnt_next;
	logic                   reported_q;
	logic                   hit_new;
	logic                   res_valid;
	logic [DW-1:0]          ofs_wide;
	logic                   m_valid_q;
	logic                   m_found_q;
	logic [OUT_W-1:0]       m_ofs_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == REG_PATTERN_LENGTH);
	assign prdata = (paddr == REG_PATTERN_LENGTH) ? APB_W'(len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if ({2'b00, len_q} > MaxC) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = len_q;
		end
	end

	// pattern ring alignment: cell j holds pattern byte (top - j) mod MAX_PATTERN
	assign aligned = (9'(top_q) == ({2'b00, len_eff} - 9'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (!aligned) begin
			top_q <= (9'(top_q) == (MaxC - 9'd1)) ? '0 : top_q + 1'b1;
		end
	end

	// input handshake
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = aligned && out_free;
	assign acc      = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign acc_text = acc && (op == OP_TEXT);
	assign acc_load = acc && (op == OP_LOAD);
	assign ld_idx   = s_tdata[IDX_W-1:0];
	assign data     = s_tdata[IDX_W+BYTE_W-1:IDX_W];

	assign ld_ok   = 9'(ld_idx) < MaxC;
	assign ld_diff = (9'(top_q) >= 9'(ld_idx)) ? 9'(top_q) - 9'(ld_idx)
		: 9'(top_q) + MaxC - 9'(ld_idx);
	assign ld_pos  = ld_diff[PW-1:0];

	assign ctrl.shift   = acc_text;
	assign ctrl.clear   = acc_text && s_tlast;
	assign ctrl.rotate  = !aligned;
	assign ctrl.len_eff = len_eff;

	// row of cells
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		localparam int PREV = (j == 0) ? MAX_PATTERN - 1 : j - 1;
		logic [BYTE_W-1:0] byte_in;
		logic              valid_in;

		if (j == 0) begin : g_head
			assign byte_in  = data;
			assign valid_in = 1'b1;
		end else begin : g_body
			assign byte_in  = win_q[j-1];
			assign valid_in = valid_vec[j-1];
		end

		bps_cell #(
			.IDX(j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.byte_in  (byte_in),
			.valid_in (valid_in),
			.pat_in   (pat_q[PREV]),
			.pat_we   (acc_load && ld_ok && (ld_pos == PW'(j))),
			.pat_wdata(data),
			.byte_q   (win_q[j]),
			.valid_q  (valid_vec[j]),
			.pat_q    (pat_q[j]),
			.hit      (hit_vec[j])
		);
	end

	assign match = &hit_vec;

	// region bookkeeping
	assign cnt_next  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign hit_new   = match && !reported_q;
	assign res_valid = acc_text && (hit_new || (s_tlast && !reported_q));
	assign ofs_wide  = DW'(cnt_next) - DW'(len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (acc_text) begin
			cnt_q      <= s_tlast ? '0 : cnt_next;
			reported_q <= s_tlast ? 1'b0 : (reported_q || hit_new);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_found_q <= hit_new;
			m_ofs_q   <= hit_new ? ofs_wide[OUT_W-1:0] : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = m_ofs_q;

`ifndef NO_ASSERTIONS
	a_valid_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("text valid bits not contiguous");

	a_reported_set: assert property (@(posedge clk) disable iff (!arst_n)
		acc_text && hit_new && !s_tlast |=> reported_q)
		else $error("match not recorded");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found word with nonzero offset");

	a_no_take_unaligned: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_we) && (pwdata[LEN_W-1:0] != $past(len_q)) && !aligned |-> !s_tready)
		else $error("word taken while pattern ring rotates");
`endif

endmodule
`default_nettype wire

[design/bps_cell.sv]
// bps_cell: one position of the search row: text byte, valid bit and
// aligned pattern byte, with its compare; depends on bps_pkg
`default_nettype none
module bps_cell #(
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bps_pkg::bps_ctrl_t        ctrl,
	input  wire logic [bps_pkg::BYTE_W-1:0] byte_in,
	input  wire logic                      valid_in,
	input  wire logic [bps_pkg::BYTE_W-1:0] pat_in,
	input  wire logic                      pat_we,
	input  wire logic [bps_pkg::BYTE_W-1:0] pat_wdata,
	output logic      [bps_pkg::BYTE_W-1:0] byte_q,
	output logic                           valid_q,
	output logic      [bps_pkg::BYTE_W-1:0] pat_q,
	output logic                           hit
);
	import bps_pkg::*;

	localparam logic [8:0] IdxC = 9'(IDX);

	logic in_use;

	assign in_use = {2'b00, ctrl.len_eff} > IdxC;
	assign hit    = !in_use || (valid_in && (byte_in == pat_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= ctrl.clear ? 1'b0 : valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
		if (ctrl.rotate) begin
			pat_q <= pat_in;
		end else if (pat_we) begin
			pat_q <= pat_wdata;
		end
	end

endmodule
`default_nettype wire
